>>> rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned CompW  = 8;   // color component width
  localparam int unsigned QuoW   = 7;   // quotient bits produced by the divider
  localparam int unsigned NumW   = CompW + QuoW;
  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ProdW  = 31;  // value numerator times reciprocal

  localparam logic [NumW-1:0] PctScale  = 15'd100;
  localparam logic [NumW-1:0] SectorDeg = 15'd60;
  localparam logic [HueW-1:0] CircleDeg = 9'd360;
  localparam logic [HueW-1:0] GreenBase = 9'd120;
  localparam logic [HueW-1:0] BlueBase  = 9'd240;

  // floor(x / 255) == (x * 0x8081) >> 23 for every x below 66052
  localparam logic [ProdW-1:0] ValRecip = 31'h0000_8081;
  localparam int unsigned      ValShift = 23;

  typedef enum logic [2:0] {
    BR_RED   = 3'b001,
    BR_GREEN = 3'b010,
    BR_BLUE  = 3'b100
  } branch_e;

  // result of the min/max front end
  typedef struct packed {
    logic [CompW-1:0] hi;
    logic [CompW-1:0] delta;
    branch_e          br;
    logic             neg;   // hue difference is negative
    logic [CompW-1:0] mag;   // magnitude of the hue difference
  } front_t;

  // per-pixel control carried down the pipe
  typedef struct packed {
    logic [CompW-1:0] hi;
    logic [CompW-1:0] delta;
    branch_e          br;
    logic             neg;
  } ctl_t;

  // one restoring-divider lane: partial remainder, numerator bits still to
  // shift in, quotient built so far
  typedef struct packed {
    logic [CompW-1:0] rem;
    logic [QuoW-1:0]  bits;
    logic [QuoW-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t h;   // hue: mag*60 / delta
    div_lane_t s;   // saturation: delta*100 / hi
  } div_pair_t;

  // quotient is known to stay below 2^QuoW, so the top bits form a
  // remainder that is already smaller than the divisor
  function automatic div_lane_t div_init(logic [NumW-1:0] num);
    div_lane_t l;
    l.rem  = num[NumW-1:QuoW];
    l.bits = num[QuoW-1:0];
    l.quo  = '0;
    return l;
  endfunction

endpackage

>>> rtl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Max/min search, branch choice and signed hue difference of one pixel.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic [rhc_pkg::CompW-1:0] red_i,
  input  logic [rhc_pkg::CompW-1:0] green_i,
  input  logic [rhc_pkg::CompW-1:0] blue_i,
  output rhc_pkg::front_t           front_o
);

  logic [rhc_pkg::CompW-1:0] hi;
  logic [rhc_pkg::CompW-1:0] lo;
  logic [rhc_pkg::CompW-1:0] op_a;
  logic [rhc_pkg::CompW-1:0] op_b;
  rhc_pkg::branch_e          br;

  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (red_i < green_i) ? red_i : green_i;
    lo = (lo < blue_i) ? lo : blue_i;

    // red wins ties over green, green over blue
    if (red_i == hi) begin
      br   = rhc_pkg::BR_RED;
      op_a = green_i;
      op_b = blue_i;
    end else if (green_i == hi) begin
      br   = rhc_pkg::BR_GREEN;
      op_a = blue_i;
      op_b = red_i;
    end else begin
      br   = rhc_pkg::BR_BLUE;
      op_a = red_i;
      op_b = green_i;
    end

    front_o.hi    = hi;
    front_o.delta = hi - lo;
    front_o.br    = br;
    front_o.neg   = (op_a < op_b);
    front_o.mag   = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
  end

endmodule

>>> rtl/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step
// One restoring-division step on both divider lanes (hue and saturation).
// ----------------------------------------------------------------------------
module rhc_div_step (
  input  rhc_pkg::ctl_t      ctl_i,
  input  rhc_pkg::div_pair_t pair_i,
  output rhc_pkg::div_pair_t pair_o
);

  function automatic rhc_pkg::div_lane_t step(rhc_pkg::div_lane_t l,
                                              logic [rhc_pkg::CompW-1:0] d);
    rhc_pkg::div_lane_t    r;
    logic [rhc_pkg::CompW:0] t;
    t = {l.rem, l.bits[rhc_pkg::QuoW-1]};
    r.bits = {l.bits[rhc_pkg::QuoW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = rhc_pkg::CompW'(t - {1'b0, d});
      r.quo = {l.quo[rhc_pkg::QuoW-2:0], 1'b1};
    end else begin
      r.rem = t[rhc_pkg::CompW-1:0];
      r.quo = {l.quo[rhc_pkg::QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

  // zero delta (grey pixel) gives junk here; it is masked at the output
  always_comb begin
    pair_o.h = step(pair_i.h, ctl_i.delta);
    pair_o.s = step(pair_i.s, ctl_i.hi);
  end

endmodule

>>> rtl/rhc_hue_out.sv
// ----------------------------------------------------------------------------
// rhc_hue_out
// Adds the sector base to the signed hue quotient and wraps into 0..359; zeroes hue and saturation for a grey pixel.
// ----------------------------------------------------------------------------
module rhc_hue_out (
  input  rhc_pkg::ctl_t                ctl_i,
  input  logic [rhc_pkg::QuoW-1:0]     hue_quo_i,
  input  logic [rhc_pkg::QuoW-1:0]     sat_quo_i,
  output logic [rhc_pkg::HueW-1:0]     hue_o,
  output logic [rhc_pkg::PctW-1:0]     sat_o
);

  logic [rhc_pkg::HueW-1:0] q;
  logic [rhc_pkg::HueW-1:0] base;
  logic                     grey;

  always_comb begin
    q    = rhc_pkg::HueW'(hue_quo_i);
    grey = (ctl_i.delta == '0);
    case (ctl_i.br)
      rhc_pkg::BR_RED:   base = '0;
      rhc_pkg::BR_GREEN: base = rhc_pkg::GreenBase;
      rhc_pkg::BR_BLUE:  base = rhc_pkg::BlueBase;
      default:           base = '0;
    endcase

    if (grey) begin
      hue_o = '0;
    end else if (!ctl_i.neg) begin
      hue_o = base + q;
    end else if (ctl_i.br == rhc_pkg::BR_RED) begin
      // negative red sector wraps, but a zero quotient stays at zero
      hue_o = (q == '0) ? '0 : (rhc_pkg::CircleDeg - q);
    end else begin
      hue_o = base - q;
    end

    sat_o = grey ? '0 : sat_quo_i;
  end

endmodule

>>> rtl/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// Integer RGB to HSV pixel converter, six-stage pipeline.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i with red_i/green_i/blue_i, in_stall_o back.
// Output channel: out_valid_o with hue_o/saturation_o/brightness_value_o,
// out_stall_i back. A transfer happens on a clock edge with valid high and
// stall low. Each pixel yields exactly one result, in order.
// Throughput: one pixel per clock while out_stall_i is low. Six register
// stages: min/max, multiplies, then a 7-step restoring divider at two
// steps per stage with the last step merged into the output stage.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles collapse. When the receiver stalls,
// the output holds; in_stall_o rises only once every stage is full.
// Reset (rst_ni low, asynchronous) empties the pipe; no pixel state is kept.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rhc_pkg::CompW-1:0]     red_i,
  input  logic [rhc_pkg::CompW-1:0]     green_i,
  input  logic [rhc_pkg::CompW-1:0]     blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rhc_pkg::HueW-1:0]      hue_o,
  output logic [rhc_pkg::PctW-1:0]      saturation_o,
  output logic [rhc_pkg::PctW-1:0]      brightness_value_o
);

  logic [6:1] v_q;
  logic [7:1] rdy;

  rhc_pkg::front_t           front;
  rhc_pkg::front_t           s1_q;
  rhc_pkg::ctl_t             ctl1;
  rhc_pkg::ctl_t             ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [rhc_pkg::NumW-1:0]  nh2_q, ns2_q, vn2_q;
  logic [rhc_pkg::ProdW-1:0] vp3_q;
  logic [rhc_pkg::PctW-1:0]  val4_q, val5_q;
  rhc_pkg::div_pair_t        p3_in, p3_mid, p3_out, p3_q;
  rhc_pkg::div_pair_t        p4_mid, p4_out, p4_q;
  rhc_pkg::div_pair_t        p5_mid, p5_out, p5_q;
  rhc_pkg::div_pair_t        p6_out;
  logic [rhc_pkg::HueW-1:0]  hue_d, hue_q;
  logic [rhc_pkg::PctW-1:0]  sat_d, sat_q, val_q;

  // ---- handshake ---------------------------------------------------------
  always_comb begin
    rdy[7] = !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---- stage 1: min/max and branch ---------------------------------------
  rhc_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .front_o (front)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) s1_q <= front;
  end

  // ---- stage 2: numerators -----------------------------------------------
  always_comb begin
    ctl1.hi    = s1_q.hi;
    ctl1.delta = s1_q.delta;
    ctl1.br    = s1_q.br;
    ctl1.neg   = s1_q.neg;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      ctl2_q <= ctl1;
      nh2_q  <= rhc_pkg::NumW'(s1_q.mag) * rhc_pkg::SectorDeg;
      ns2_q  <= rhc_pkg::NumW'(s1_q.delta) * rhc_pkg::PctScale;
      vn2_q  <= rhc_pkg::NumW'(s1_q.hi) * rhc_pkg::PctScale;
    end
  end

  // ---- stage 3: divide steps 1-2, value reciprocal multiply --------------
  always_comb begin
    p3_in.h = rhc_pkg::div_init(nh2_q);
    p3_in.s = rhc_pkg::div_init(ns2_q);
  end

  rhc_div_step u_div1 (.ctl_i(ctl2_q), .pair_i(p3_in),  .pair_o(p3_mid));
  rhc_div_step u_div2 (.ctl_i(ctl2_q), .pair_i(p3_mid), .pair_o(p3_out));

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      ctl3_q <= ctl2_q;
      p3_q   <= p3_out;
      vp3_q  <= rhc_pkg::ProdW'(vn2_q) * rhc_pkg::ValRecip;
    end
  end

  // ---- stage 4: divide steps 3-4 -----------------------------------------
  rhc_div_step u_div3 (.ctl_i(ctl3_q), .pair_i(p3_q),   .pair_o(p4_mid));
  rhc_div_step u_div4 (.ctl_i(ctl3_q), .pair_i(p4_mid), .pair_o(p4_out));

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      ctl4_q <= ctl3_q;
      p4_q   <= p4_out;
      val4_q <= vp3_q[rhc_pkg::ValShift+rhc_pkg::PctW-1:rhc_pkg::ValShift];
    end
  end

  // ---- stage 5: divide steps 5-6 -----------------------------------------
  rhc_div_step u_div5 (.ctl_i(ctl4_q), .pair_i(p4_q),   .pair_o(p5_mid));
  rhc_div_step u_div6 (.ctl_i(ctl4_q), .pair_i(p5_mid), .pair_o(p5_out));

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      ctl5_q <= ctl4_q;
      p5_q   <= p5_out;
      val5_q <= val4_q;
    end
  end

  // ---- stage 6: last divide step, hue assembly, output register ----------
  rhc_div_step u_div7 (.ctl_i(ctl5_q), .pair_i(p5_q), .pair_o(p6_out));

  rhc_hue_out u_hue (
    .ctl_i     (ctl5_q),
    .hue_quo_i (p6_out.h.quo),
    .sat_quo_i (p6_out.s.quo),
    .hue_o     (hue_d),
    .sat_o     (sat_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val5_q;
    end
  end

  assign hue_o              = hue_q;
  assign saturation_o       = sat_q;
  assign brightness_value_o = val_q;

  // ---- assertions --------------------------------------------------------
  logic [2:0] occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 3'(in_valid_i && !in_stall_o) - 3'(out_valid_o && !out_stall_i);
    end
  end

  // items in flight match the stage valid bits: nothing dropped or doubled
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == 3'($countones(v_q)))
    else $error("pipeline occupancy mismatch");

  // input is held off only when every stage is full and the output stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_q == '1) && out_stall_i)
    else $error("input stalled with room in the pipe");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < rhc_pkg::CircleDeg) && (saturation_o <= 7'd100) &&
                    (brightness_value_o <= 7'd100))
    else $error("result out of range");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Pixel stream test for rgb_to_hsv_convert. A queue of pixels (directed
// corner cases first, then random pixels biased toward grey, tied maxima,
// small deltas and extreme components) feeds a valid/stall driver. Each
// pixel's HSV is predicted when it is presented. A monitor checks every
// output transfer in order. Both sides idle in random bursts, except near
// the end of the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int PercentFull  = 100;
  localparam int CompFull     = 255;
  localparam int SectorDeg    = 60;
  localparam int CircleDeg    = 360;
  localparam int RandomPixels = 500;
  localparam int CalmPixels   = 60;    // tail of the run with no idling
  localparam int ReportMax    = 10;
  localparam int IdleLimit    = 1000;  // cycles without any transfer
  localparam int DrainCycles  = 20;

  typedef struct packed {
    logic [rhc_pkg::CompW-1:0] red;
    logic [rhc_pkg::CompW-1:0] green;
    logic [rhc_pkg::CompW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [rhc_pkg::HueW-1:0] hue;
    logic [rhc_pkg::PctW-1:0] saturation;
    logic [rhc_pkg::PctW-1:0] brightness_value;
  } hsv_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [rhc_pkg::CompW-1:0] red_i = '0;
  logic [rhc_pkg::CompW-1:0] green_i = '0;
  logic [rhc_pkg::CompW-1:0] blue_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [rhc_pkg::HueW-1:0]  hue_o;
  logic [rhc_pkg::PctW-1:0]  saturation_o;
  logic [rhc_pkg::PctW-1:0]  brightness_value_o;

  pixel_t pending_pixels[$];
  hsv_t   hsv_expected[$];
  int     mismatch_count = 0;
  int     result_idx = 0;
  int     in_gap = 0;
  int     out_gap = 0;
  int     idle_cycles = 0;
  logic   tail_calm = 1'b0;

  rgb_to_hsv_convert u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hue_o              (hue_o),
    .saturation_o       (saturation_o),
    .brightness_value_o (brightness_value_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic hsv_t hsv_of(pixel_t p);
    int               r, g, b, hi, lo, delta, h, sat, val;
    rhc_pkg::branch_e br;
    hsv_t             res;
    r = p.red;
    g = p.green;
    b = p.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    val = (hi * PercentFull) / CompFull;
    h = 0;
    sat = 0;
    if (delta != 0) begin
      sat = (delta * PercentFull) / hi;
      // ties go to red first, then green
      if (r == hi) br = rhc_pkg::BR_RED;
      else if (g == hi) br = rhc_pkg::BR_GREEN;
      else br = rhc_pkg::BR_BLUE;
      case (br)
        rhc_pkg::BR_RED:   h = ((g - b) * SectorDeg) / delta;
        rhc_pkg::BR_GREEN: h = 2 * SectorDeg + ((b - r) * SectorDeg) / delta;
        default:           h = 4 * SectorDeg + ((r - g) * SectorDeg) / delta;
      endcase
      // int division truncates toward zero, so (-1, 0) lands on 0
      if (h < 0) h += CircleDeg;
    end
    res.hue = h[rhc_pkg::HueW-1:0];
    res.saturation = sat[rhc_pkg::PctW-1:0];
    res.brightness_value = val[rhc_pkg::PctW-1:0];
    return res;
  endfunction

  function automatic logic [rhc_pkg::CompW-1:0] extreme_comp();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pixel_t p;
    p.red = r[7:0];
    p.green = g[7:0];
    p.blue = b[7:0];
    pending_pixels.push_back(p);
  endtask

  task automatic add_random_pixel();
    int r, g, b, m, o, base;
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      5: begin
        g = r;
        b = r;
      end
      6: begin
        // two components share the maximum
        m = $urandom_range(1, 255);
        o = $urandom_range(0, m);
        case ($urandom_range(0, 2))
          0: begin r = m; g = m; b = o; end
          1: begin r = o; g = m; b = m; end
          default: begin r = m; g = o; b = m; end
        endcase
      end
      7: begin
        base = $urandom_range(0, 252);
        r = base + $urandom_range(0, 3);
        g = base + $urandom_range(0, 3);
        b = base + $urandom_range(0, 3);
      end
      8: begin
        r = extreme_comp();
        g = extreme_comp();
        b = extreme_comp();
      end
      default: ;
    endcase
    add_pixel(r, g, b);
  endtask

  task automatic check_hsv(hsv_t got);
    hsv_t want;
    if (hsv_expected.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportMax)
        $display("result %0d with no pixel pending: h=%0d s=%0d v=%0d", result_idx,
                 got.hue, got.saturation, got.brightness_value);
    end else begin
      want = hsv_expected.pop_front();
      if (got.hue !== want.hue || got.saturation !== want.saturation ||
          got.brightness_value !== want.brightness_value) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("result %0d: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                   result_idx, want.hue, want.saturation, want.brightness_value,
                   got.hue, got.saturation, got.brightness_value);
      end
    end
    result_idx++;
  endtask

  // driver: presents the next pixel once the current one has transferred, with random idle gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      red_i <= '0;
      green_i <= '0;
      blue_i <= '0;
      in_gap <= 0;
      tail_calm <= 1'b0;
    end else begin
      tail_calm <= (pending_pixels.size() < CalmPixels);
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_pixels.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 4) == 0) begin
          in_valid_i <= 1'b0;
          in_gap <= $urandom_range(0, 4);
        end else begin
          pixel_t p;
          p = pending_pixels.pop_front();
          hsv_expected.push_back(hsv_of(p));
          red_i <= p.red;
          green_i <= p.green;
          blue_i <= p.blue;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor: checks each output transfer and stalls in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i)
        check_hsv('{hue: hue_o, saturation: saturation_o,
                    brightness_value: brightness_value_o});
      if (out_gap != 0) begin
        out_stall_i <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (!tail_calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        out_gap <= $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("rgb_to_hsv_convert: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // grey, black and white
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    // primaries and their smallest nonzero forms
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    // tied maxima: red over green, green over blue, red over blue
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(1, 1, 0);
    // slightly negative quotient truncates to 0; a larger one wraps to 359
    add_pixel(255, 0, 1);
    add_pixel(255, 0, 5);
    // low saturation and small branch offsets
    add_pixel(255, 254, 254);
    add_pixel(0, 255, 1);
    add_pixel(1, 0, 255);
    add_pixel(200, 10, 100);
    add_pixel(170, 85, 0);
    add_pixel(0, 128, 255);
    add_pixel(127, 128, 254);
    repeat (RandomPixels) add_random_pixel();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_pixels.size() != 0 || in_valid_i) @(posedge clk_i);
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && hsv_expected.size() == 0) begin
      $display("rgb_to_hsv_convert: match");
    end else begin
      $display("rgb_to_hsv_convert: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rhc_pkg.sv
rtl/rhc_front.sv
rtl/rhc_div_step.sv
rtl/rhc_hue_out.sv
rtl/rgb_to_hsv_convert.sv
dv/tb.sv
